// ===== rtl/hmf_pkg.sv =====
// ----------------------------------------------------------------------------
// hmf_pkg
// Shared types and constants of the HID message framer.
// ----------------------------------------------------------------------------
package hmf_pkg;

    localparam int BODY_BYTES_DEF  = 59;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FILL_W          = 6;

    localparam logic [15:0] CHANNEL_ID_RST = 16'h0101;
    localparam logic [7:0]  COMMAND_TAG_RST = 8'h05;

    typedef enum logic [1:0] {
        CFG_CHANNEL_ID  = 2'd0,
        CFG_COMMAND_TAG = 2'd1,
        CFG_PAD_LAST    = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_START,
        PH_CH_HI,
        PH_CH_LO,
        PH_TAG,
        PH_SEQ_HI,
        PH_SEQ_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_PAD
    } t_phase;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              hdr;
        logic              len_hdr;
        logic [15:0]       length;
        logic [15:0]       seq;
        logic              eof;
        logic              eom;
        logic [FILL_W-1:0] pad_cnt;
    } t_cmd;

endpackage

// ===== rtl/hmf_in_if.sv =====
// ----------------------------------------------------------------------------
// hmf_in_if
// Payload byte channel into the framer.
// ----------------------------------------------------------------------------
interface hmf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_of_message;
    logic [15:0] message_length;

    modport source (output valid, output data_byte, output first_of_message,
                    output message_length, input ready);
    modport sink   (input valid, input data_byte, input first_of_message,
                    input message_length, output ready);
endinterface

// ===== rtl/hmf_out_if.sv =====
// ----------------------------------------------------------------------------
// hmf_out_if
// Frame byte channel out of the framer.
// ----------------------------------------------------------------------------
interface hmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic       end_of_message;

    modport source (output valid, output frame_byte, output end_of_frame,
                    output end_of_message, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame,
                    input end_of_message, output ready);
endinterface

// ===== rtl/hmf_front.sv =====
// ----------------------------------------------------------------------------
// hmf_front
// Accepts payload beats, tracks frame state and issues one command per beat of a message with bytes left.
// ----------------------------------------------------------------------------
module hmf_front #(
    parameter int BODY_BYTES = hmf_pkg::BODY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hmf_in_if.sink            i_in,
    input  logic              i_pad_last,
    input  logic              i_q_full,
    output logic              o_push,
    output hmf_pkg::t_cmd     o_cmd
);

    localparam logic [hmf_pkg::FILL_W-1:0] BODY_N = hmf_pkg::FILL_W'(BODY_BYTES);

    logic [15:0]               r_seq, n_seq;
    logic [15:0]               r_rem, n_rem;
    logic [hmf_pkg::FILL_W-1:0] r_fill, n_fill;

    logic                      accept;
    logic                      active;
    logic [15:0]               seq_used;
    logic [15:0]               rem_after;
    logic [hmf_pkg::FILL_W-1:0] fill_after;
    logic                      full;
    logic                      last;
    logic                      pad;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_in.first_of_message) begin
            active     = (i_in.message_length != 16'd0);
            seq_used   = 16'd0;
            rem_after  = i_in.message_length - 16'd1;
            fill_after = hmf_pkg::FILL_W'(3);
        end else begin
            active     = (r_rem != 16'd0);
            seq_used   = r_seq;
            rem_after  = r_rem - 16'd1;
            fill_after = r_fill + hmf_pkg::FILL_W'(1);
        end
        full = (fill_after >= BODY_N);
        last = (rem_after == 16'd0);
        pad  = last && i_pad_last && !full;
    end

    always_comb begin
        o_push          = accept && active;
        o_cmd.data_byte = i_in.data_byte;
        o_cmd.hdr       = i_in.first_of_message || (r_fill == '0);
        o_cmd.len_hdr   = i_in.first_of_message;
        o_cmd.length    = i_in.message_length;
        o_cmd.seq       = seq_used;
        o_cmd.eof       = !pad && (full || last);
        o_cmd.eom       = !pad && last;
        o_cmd.pad_cnt   = pad ? (BODY_N - fill_after) : '0;
    end

    always_comb begin
        n_seq  = r_seq;
        n_rem  = r_rem;
        n_fill = r_fill;
        if (accept) begin
            if (i_in.first_of_message && !active) begin
                n_seq  = 16'd0;
                n_rem  = 16'd0;
                n_fill = '0;
            end else if (active) begin
                n_rem = rem_after;
                if (full || last) begin
                    n_fill = '0;
                    n_seq  = seq_used + 16'd1;
                end else begin
                    n_fill = fill_after;
                    n_seq  = seq_used;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= '0;
            r_rem  <= '0;
            r_fill <= '0;
        end else begin
            r_seq  <= n_seq;
            r_rem  <= n_rem;
            r_fill <= n_fill;
        end
    end

    a_len_has_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.len_hdr |-> o_cmd.hdr)
        else $error("length bytes without header");
    a_pad_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_cmd.pad_cnt != '0) |-> !o_cmd.eof && !o_cmd.eom)
        else $error("padded data byte carries end mark");
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("command pushed into full queue");

endmodule

// ===== rtl/hmf_queue.sv =====
// ----------------------------------------------------------------------------
// hmf_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module hmf_queue #(
    parameter int DEPTH = hmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hmf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output hmf_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hmf_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/hmf_back.sv =====
// ----------------------------------------------------------------------------
// hmf_back
// Expands queued commands into header, length, data and pad bytes.
// ----------------------------------------------------------------------------
module hmf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  hmf_pkg::t_cmd i_head,
    input  logic [15:0]   i_channel_id,
    input  logic [7:0]    i_command_tag,
    output logic          o_pop,
    hmf_out_if.source     o_out
);

    hmf_pkg::t_phase            r_phase, n_phase;
    hmf_pkg::t_phase            eff_phase;
    logic [hmf_pkg::FILL_W-1:0] r_pad_left, n_pad_left;
    logic                       r_valid;
    logic [7:0]                 r_byte;
    logic                       r_eof;
    logic                       r_eom;

    logic                       advance;
    logic                       step;
    logic [7:0]                 c_byte;
    logic                       c_eof;
    logic                       c_eom;
    logic                       c_done;

    assign advance = !r_valid || o_out.ready;
    assign step    = advance && i_head_valid;

    always_comb begin
        if (r_phase == hmf_pkg::PH_START) begin
            eff_phase = i_head.hdr ? hmf_pkg::PH_CH_HI : hmf_pkg::PH_DATA;
        end else begin
            eff_phase = r_phase;
        end
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_pad_left = r_pad_left;
        if (step) begin
            unique case (eff_phase)
                hmf_pkg::PH_CH_HI:  n_phase = hmf_pkg::PH_CH_LO;
                hmf_pkg::PH_CH_LO:  n_phase = hmf_pkg::PH_TAG;
                hmf_pkg::PH_TAG:    n_phase = hmf_pkg::PH_SEQ_HI;
                hmf_pkg::PH_SEQ_HI: n_phase = hmf_pkg::PH_SEQ_LO;
                hmf_pkg::PH_SEQ_LO: begin
                    n_phase = i_head.len_hdr ? hmf_pkg::PH_LEN_HI : hmf_pkg::PH_DATA;
                end
                hmf_pkg::PH_LEN_HI: n_phase = hmf_pkg::PH_LEN_LO;
                hmf_pkg::PH_LEN_LO: n_phase = hmf_pkg::PH_DATA;
                hmf_pkg::PH_DATA: begin
                    n_pad_left = i_head.pad_cnt;
                    n_phase    = (i_head.pad_cnt != '0) ? hmf_pkg::PH_PAD
                                                        : hmf_pkg::PH_START;
                end
                hmf_pkg::PH_PAD: begin
                    n_pad_left = r_pad_left - hmf_pkg::FILL_W'(1);
                    n_phase    = (r_pad_left == hmf_pkg::FILL_W'(1)) ? hmf_pkg::PH_START
                                                                    : hmf_pkg::PH_PAD;
                end
                default:            n_phase = hmf_pkg::PH_START;
            endcase
        end
    end

    // beat contents
    always_comb begin
        c_byte = 8'h00;
        c_eof  = 1'b0;
        c_eom  = 1'b0;
        c_done = 1'b0;
        unique case (eff_phase)
            hmf_pkg::PH_CH_HI:  c_byte = i_channel_id[15:8];
            hmf_pkg::PH_CH_LO:  c_byte = i_channel_id[7:0];
            hmf_pkg::PH_TAG:    c_byte = i_command_tag;
            hmf_pkg::PH_SEQ_HI: c_byte = i_head.seq[15:8];
            hmf_pkg::PH_SEQ_LO: c_byte = i_head.seq[7:0];
            hmf_pkg::PH_LEN_HI: c_byte = i_head.length[15:8];
            hmf_pkg::PH_LEN_LO: c_byte = i_head.length[7:0];
            hmf_pkg::PH_DATA: begin
                c_byte = i_head.data_byte;
                c_eof  = i_head.eof;
                c_eom  = i_head.eom;
                c_done = (i_head.pad_cnt == '0);
            end
            hmf_pkg::PH_PAD: begin
                c_eof  = (r_pad_left == hmf_pkg::FILL_W'(1));
                c_eom  = (r_pad_left == hmf_pkg::FILL_W'(1));
                c_done = (r_pad_left == hmf_pkg::FILL_W'(1));
            end
            default:            c_byte = 8'h00;
        endcase
    end

    assign o_pop = step && c_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hmf_pkg::PH_START;
            r_pad_left <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pad_left <= n_pad_left;
            if (advance) begin
                r_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= c_byte;
            r_eof  <= c_eof;
            r_eom  <= c_eom;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.frame_byte     = r_byte;
    assign o_out.end_of_frame   = r_eof;
    assign o_out.end_of_message = r_eom;

    a_eom_is_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_eom |-> r_eof)
        else $error("end of message without end of frame");
    a_pop_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (eff_phase == hmf_pkg::PH_DATA) || (eff_phase == hmf_pkg::PH_PAD))
        else $error("command retired outside body phase");
    a_pad_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hmf_pkg::PH_PAD |-> r_pad_left != '0)
        else $error("pad phase with no pad bytes left");

endmodule

// ===== rtl/hid_message_framer_core.sv =====
// An accepted beat passes through the command queue and then the output byte register.
// Throughput: one frame byte per cycle if the output is ready; a payload beat expands
//   to 1, 6 or 8 bytes, or up to 5 + BODY_BYTES with padding; the output byte sequencer
//   sets the rate. Input beats are taken every cycle while the command queue has room.
// Reset (synchronous, active low) clears frame state, queue and output; registers
//   return to channel 0x0101, tag 0x05, padding off.
// ----------------------------------------------------------------------------
// hid_message_framer_core
// Splits payload messages into HID report frames with header and sequence.
// ----------------------------------------------------------------------------
module hid_message_framer_core #(
    parameter int BODY_BYTES  = hmf_pkg::BODY_BYTES_DEF,
    parameter int QUEUE_DEPTH = hmf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmf_in_if.sink      i_in,
    hmf_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]   r_channel_id;
    logic [7:0]    r_command_tag;
    logic          r_pad_last;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    hmf_pkg::t_cmd cmd;
    hmf_pkg::t_cmd head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_id  <= hmf_pkg::CHANNEL_ID_RST;
            r_command_tag <= hmf_pkg::COMMAND_TAG_RST;
            r_pad_last    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (hmf_pkg::t_cfg_idx'(i_cfg_index))
                hmf_pkg::CFG_CHANNEL_ID:  r_channel_id  <= i_cfg_data;
                hmf_pkg::CFG_COMMAND_TAG: r_command_tag <= i_cfg_data[7:0];
                hmf_pkg::CFG_PAD_LAST:    r_pad_last    <= i_cfg_data[0];
                default:                  r_pad_last    <= r_pad_last;
            endcase
        end
    end

    hmf_front #(
        .BODY_BYTES (BODY_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_pad_last (r_pad_last),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    hmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    hmf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_valid),
        .i_head        (head),
        .i_channel_id  (r_channel_id),
        .i_command_tag (r_command_tag),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule
